[hw/rtl/sorted_recent_window_assert.svh]
// Assertion macros for the sorted recent window block.
// Included by the controller and the datapath; no other dependencies.
`ifndef SORTED_RECENT_WINDOW_ASSERT_SVH
`define SORTED_RECENT_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS

`define SRW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: %m");

`define SRW_ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen: %m");

`else

`define SRW_ASSERT(lbl, clk, rst_n, prop)

`define SRW_ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

[hw/rtl/srw_pkg.sv]
// Shared constants, codes and types of the sorted recent window block.
// Used by srw_ctrl, srw_dp and sorted_recent_window; depends on nothing.
package srw_pkg;

	localparam int WIN_DEPTH = 32;
	localparam int ADDR_W    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

	localparam int KIND_W   = 2;
	localparam int TIME_W   = 31;
	localparam int SERVER_W = 4;
	localparam int TAG_W    = 16;
	localparam int LINE_W   = 6;
	localparam int STATUS_W = 3;
	localparam int FILL_W   = 6;
	localparam int KEY_W    = TIME_W + SERVER_W;

	// input beat layout
	localparam int IN_SERVER_LSB = TIME_W;
	localparam int IN_TAG_LSB    = IN_SERVER_LSB + SERVER_W;
	localparam int IN_LINE_LSB   = IN_TAG_LSB + TAG_W;
	localparam int IN_USED_W     = IN_LINE_LSB + LINE_W;
	localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

	// output beat layout
	localparam int OUT_USED_W = STATUS_W + 1 + TIME_W + SERVER_W + TAG_W + FILL_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0]   ts;
		logic [SERVER_W-1:0] server;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic                load;
		logic                clear;
		logic                scan;
		logic                shift_setup;
		logic                shift;
		logic                place;
		logic                read_line;
		logic                finish;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic held_zero;
		logic scan_done;
		logic key_eq;
		logic pos_zero;
		logic full;
		logic shift_idle;
		logic out_free;
	} sts_t;

endpackage

[hw/rtl/srw_ctrl.sv]
// Sequencing state machine of the sorted recent window block.
// Depends on srw_pkg and sorted_recent_window_assert.svh.
`include "sorted_recent_window_assert.svh"

module srw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [srw_pkg::KIND_W-1:0]  kind,
	input  srw_pkg::sts_t               sts,
	output srw_pkg::cmd_t               cmd,
	output logic                        ready
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_PLACE  = 7'b0010000,
		S_READ   = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t                          state_q, state_d;
	logic [srw_pkg::STATUS_W-1:0]    status_q, status_d;

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		cmd        = '0;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load  = 1'b1;
					cmd.clear = (kind == srw_pkg::KIND_CLEAR);
					status_d  = srw_pkg::ST_NONE;
					case (kind)
						srw_pkg::KIND_INSERT: begin
							if (sts.held_zero) begin
								status_d = srw_pkg::ST_NEW;
								state_d  = S_PLACE;
							end else begin
								state_d = S_SCAN;
							end
						end
						srw_pkg::KIND_READ: state_d = S_READ;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.key_eq) begin
					status_d = srw_pkg::ST_REPLACED;
					state_d  = S_PLACE;
				end else if (sts.pos_zero) begin
					status_d = srw_pkg::ST_REJECTED;
					state_d  = S_RESP;
				end else begin
					cmd.shift_setup = 1'b1;
					status_d = sts.full ? srw_pkg::ST_EVICTED : srw_pkg::ST_NEW;
					state_d  = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_idle) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_RESP;
			end
			S_READ: begin
				cmd.read_line = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= srw_pkg::ST_NONE;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	assign ready = (state_q == S_IDLE);

	`SRW_ASSERT(a_load_leaves_idle, clk, arst_n, cmd.load |=> !ready)
	`SRW_ASSERT(a_shift_then_place, clk, arst_n, (state_q == S_SHIFT && sts.shift_idle) |=> cmd.place)
	`SRW_ASSERT(a_finish_then_ready, clk, arst_n, cmd.finish |=> ready)

endmodule

[hw/rtl/srw_dp.sv]
// Datapath of the sorted recent window: entry memory, scan and shift
// pointers, fill count and output register. Depends on srw_pkg and
// sorted_recent_window_assert.svh.
`include "sorted_recent_window_assert.svh"

module srw_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [srw_pkg::IN_DATA_W-1:0]  in_data,
	input  srw_pkg::cmd_t                  cmd,
	output srw_pkg::sts_t                  sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [srw_pkg::OUT_DATA_W-1:0] out_data
);

	localparam int CMP_W = srw_pkg::CNT_W + srw_pkg::LINE_W;

	srw_pkg::entry_t                  mem [srw_pkg::WIN_DEPTH];
	srw_pkg::entry_t                  new_q;
	srw_pkg::entry_t                  rdata_q;
	srw_pkg::entry_t                  rd_fields;
	logic [srw_pkg::LINE_W-1:0]       line_q;
	logic [srw_pkg::CNT_W-1:0]        held_q, ptr_q, pos_q, sh_left_q;
	logic                             eq_q, rd_item_q;
	logic                             rd_vld_s1, rd_shift_s1;
	logic [srw_pkg::ADDR_W-1:0]       addr_s1;
	logic                             out_vld_q;
	logic [srw_pkg::OUT_DATA_W-1:0]   out_q;

	logic [srw_pkg::KEY_W-1:0]        new_key, rd_key;
	logic                             key_le, key_same, last_addr, scan_hit, full;
	logic                             scan_issue, shift_issue, rd_en, we, line_ok, out_free;
	logic [srw_pkg::CNT_W-1:0]        held_m1, pos_m1;
	logic [srw_pkg::LINE_W-1:0]       line_m1;
	logic [srw_pkg::ADDR_W-1:0]       rd_addr, waddr, shift_dst, place_addr;
	srw_pkg::entry_t                  wdata;

	assign new_key   = {new_q.ts, new_q.server};
	assign rd_key    = {rdata_q.ts, rdata_q.server};
	assign key_le    = (new_key <= rd_key);
	assign key_same  = (new_key == rd_key);
	assign held_m1   = held_q - srw_pkg::CNT_W'(1);
	assign pos_m1    = pos_q - srw_pkg::CNT_W'(1);
	assign full      = (held_q == srw_pkg::CNT_W'(srw_pkg::WIN_DEPTH));
	assign last_addr = (addr_s1 == held_m1[srw_pkg::ADDR_W-1:0]);

	// scan stops at the first stored key not below the new one, or at the end
	assign scan_hit    = cmd.scan && rd_vld_s1 && (key_le || last_addr);
	assign scan_issue  = cmd.scan && !scan_hit && (ptr_q < held_q);
	assign shift_issue = cmd.shift && (sh_left_q != '0);
	assign rd_en       = scan_issue || shift_issue || cmd.read_line;

	assign line_m1 = line_q - srw_pkg::LINE_W'(1);
	assign rd_addr = cmd.read_line ? srw_pkg::ADDR_W'(line_m1) : ptr_q[srw_pkg::ADDR_W-1:0];
	assign line_ok = (line_q != '0) && (CMP_W'(line_q) <= CMP_W'(held_q));

	// full window moves entries towards position 0, otherwise towards the top
	assign shift_dst  = full ? (addr_s1 - srw_pkg::ADDR_W'(1)) : (addr_s1 + srw_pkg::ADDR_W'(1));
	assign place_addr = (full && !eq_q) ? pos_m1[srw_pkg::ADDR_W-1:0]
	                                    : pos_q[srw_pkg::ADDR_W-1:0];
	assign we    = (rd_vld_s1 && rd_shift_s1) || cmd.place;
	assign waddr = cmd.place ? place_addr : shift_dst;
	assign wdata = cmd.place ? new_q : rdata_q;

	assign out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		addr_s1 <= rd_addr;
		if (cmd.load) begin
			new_q.ts     <= in_data[0 +: srw_pkg::TIME_W];
			new_q.server <= in_data[srw_pkg::IN_SERVER_LSB +: srw_pkg::SERVER_W];
			new_q.tag    <= in_data[srw_pkg::IN_TAG_LSB +: srw_pkg::TAG_W];
			line_q       <= in_data[srw_pkg::IN_LINE_LSB +: srw_pkg::LINE_W];
		end
		if (cmd.finish) begin
			out_q <= {{srw_pkg::OUT_PAD_W{1'b0}},
			          srw_pkg::FILL_W'(held_q),
			          rd_fields.tag, rd_fields.server, rd_fields.ts,
			          rd_item_q && line_ok,
			          cmd.status};
		end
	end

	assign rd_fields = (rd_item_q && line_ok) ? rdata_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			ptr_q       <= '0;
			pos_q       <= '0;
			sh_left_q   <= '0;
			eq_q        <= 1'b0;
			rd_item_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_shift_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			rd_shift_s1 <= shift_issue;
			if (cmd.load) begin
				ptr_q     <= '0;
				pos_q     <= '0;
				eq_q      <= 1'b0;
				rd_item_q <= 1'b0;
				if (cmd.clear) begin
					held_q <= '0;
				end
			end
			if (cmd.read_line) begin
				rd_item_q <= 1'b1;
			end
			if (scan_issue) begin
				ptr_q <= ptr_q + srw_pkg::CNT_W'(1);
			end
			if (scan_hit) begin
				pos_q <= key_le ? srw_pkg::CNT_W'(addr_s1) : held_q;
				eq_q  <= key_le && key_same;
			end
			if (cmd.shift_setup) begin
				if (full) begin
					ptr_q     <= srw_pkg::CNT_W'(1);
					sh_left_q <= pos_m1;
				end else begin
					ptr_q     <= held_m1;
					sh_left_q <= held_q - pos_q;
				end
			end
			if (shift_issue) begin
				ptr_q     <= full ? (ptr_q + srw_pkg::CNT_W'(1)) : (ptr_q - srw_pkg::CNT_W'(1));
				sh_left_q <= sh_left_q - srw_pkg::CNT_W'(1);
			end
			if (cmd.place && !full && !eq_q) begin
				held_q <= held_q + srw_pkg::CNT_W'(1);
			end
			if (cmd.finish) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign sts.held_zero  = (held_q == '0);
	assign sts.scan_done  = scan_hit;
	assign sts.key_eq     = eq_q;
	assign sts.pos_zero   = (pos_q == '0);
	assign sts.full       = full;
	assign sts.shift_idle = (sh_left_q == '0) && !rd_vld_s1;
	assign sts.out_free   = out_free;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`SRW_ASSERT(a_held_bound, clk, arst_n, held_q <= srw_pkg::CNT_W'(srw_pkg::WIN_DEPTH))
	`SRW_ASSERT_NEVER(a_place_vs_shift, clk, arst_n, cmd.place && rd_vld_s1)
	`SRW_ASSERT_NEVER(a_scan_writes, clk, arst_n, cmd.scan && we)

endmodule

[hw/rtl/sorted_recent_window.sv]
// Top level of the sorted recent window block: stream ports, controller
// and datapath. Depends on srw_pkg, srw_ctrl and srw_dp.
//
// Keeps up to 32 entries ordered by (timestamp, server), oldest at line 1,
// and takes one item at a time, giving one result beat per item. An insert
// into a window holding n entries scans the stored keys one per cycle from
// the oldest. It then moves the entries above the insertion point one per
// cycle, or, when the window is full, the entries below it. The entry memory
// takes one read and one write a cycle. An insert into an empty window is
// placed without a scan, a read fetches the requested line, and a clear or
// an unused kind goes straight to the result. A new item is taken while the
// previous result still waits in the output register.
module sorted_recent_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// msg_timestamp, msg_server, msg_tag, line_no, zero pad
	input  logic [srw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [srw_pkg::KIND_W-1:0]     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// insert_status, read_valid, read_timestamp, read_server, read_tag,
	// fill_count, zero pad
	output logic [srw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	srw_pkg::cmd_t cmd;
	srw_pkg::sts_t sts;
	logic          accept;

	assign accept = s_axis_tvalid && s_axis_tready;

	srw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (s_axis_tuser),
		.sts    (sts),
		.cmd    (cmd),
		.ready  (s_axis_tready)
	);

	srw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

[dv/sorted_recent_window_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_recent_window: random stream traffic, a window model
// and a result scoreboard in one file. Depends on srw_pkg and the block's RTL.
module sorted_recent_window_tb;

	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 1400;
	localparam logic [srw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [srw_pkg::STATUS_W-1:0] status;
		logic                         hit;
		logic [srw_pkg::TIME_W-1:0]   ts;
		logic [srw_pkg::SERVER_W-1:0] server;
		logic [srw_pkg::TAG_W-1:0]    tag;
		logic [srw_pkg::FILL_W-1:0]   fill;
	} window_result_t;

	class window_scoreboard;
		srw_pkg::entry_t lines[srw_pkg::WIN_DEPTH];
		int unsigned     held;
		window_result_t  pending_results[$];
		int unsigned     errors;
		int unsigned     checked;
		int unsigned     status_seen[5];
		int unsigned     reads_hit;
		int unsigned     reads_miss;

		function new();
			held = 0;
			errors = 0;
			checked = 0;
			reads_hit = 0;
			reads_miss = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// place one entry in key order, returning the insert status
		function logic [srw_pkg::STATUS_W-1:0] place_entry(srw_pkg::entry_t e);
			logic [srw_pkg::KEY_W-1:0] k;
			int unsigned               p;
			k = {e.ts, e.server};
			if (held == 0) begin
				lines[0] = e;
				held = 1;
				return srw_pkg::ST_NEW;
			end
			if (k < {lines[0].ts, lines[0].server})
				return srw_pkg::ST_REJECTED;
			p = 0;
			while (p < held) begin
				if (k == {lines[p].ts, lines[p].server}) begin
					lines[p] = e;
					return srw_pkg::ST_REPLACED;
				end
				if (k < {lines[p].ts, lines[p].server})
					break;
				p++;
			end
			if (held < srw_pkg::WIN_DEPTH) begin
				for (int i = held; i > p; i--)
					lines[i] = lines[i-1];
				lines[p] = e;
				held++;
				return srw_pkg::ST_NEW;
			end
			// full: drop the oldest and slide the lower part down
			for (int i = 0; i + 1 < p; i++)
				lines[i] = lines[i+1];
			lines[p-1] = e;
			return srw_pkg::ST_EVICTED;
		endfunction

		function void note_item(logic [srw_pkg::KIND_W-1:0] kind,
				logic [srw_pkg::IN_DATA_W-1:0] data);
			window_result_t             r;
			srw_pkg::entry_t            e;
			logic [srw_pkg::LINE_W-1:0] line;
			e.ts     = data[srw_pkg::TIME_W-1:0];
			e.server = data[srw_pkg::IN_SERVER_LSB +: srw_pkg::SERVER_W];
			e.tag    = data[srw_pkg::IN_TAG_LSB +: srw_pkg::TAG_W];
			line     = data[srw_pkg::IN_LINE_LSB +: srw_pkg::LINE_W];
			r.status = srw_pkg::ST_NONE;
			r.hit    = 1'b0;
			r.ts     = '0;
			r.server = '0;
			r.tag    = '0;
			case (kind)
				srw_pkg::KIND_INSERT: begin
					r.status = place_entry(e);
				end
				srw_pkg::KIND_READ: begin
					if (line >= 1 && line <= held) begin
						r.hit    = 1'b1;
						r.ts     = lines[line-1].ts;
						r.server = lines[line-1].server;
						r.tag    = lines[line-1].tag;
						reads_hit++;
					end else begin
						reads_miss++;
					end
				end
				srw_pkg::KIND_CLEAR: begin
					held = 0;
				end
				default: ;
			endcase
			r.fill = held[srw_pkg::FILL_W-1:0];
			status_seen[r.status]++;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [srw_pkg::OUT_DATA_W-1:0] data);
			window_result_t want;
			window_result_t got;
			got.status = data[srw_pkg::STATUS_W-1:0];
			got.hit    = data[srw_pkg::STATUS_W];
			got.ts     = data[srw_pkg::STATUS_W+1 +: srw_pkg::TIME_W];
			got.server = data[srw_pkg::STATUS_W+1+srw_pkg::TIME_W +: srw_pkg::SERVER_W];
			got.tag    = data[srw_pkg::STATUS_W+1+srw_pkg::TIME_W+srw_pkg::SERVER_W
				+: srw_pkg::TAG_W];
			got.fill   = data[srw_pkg::STATUS_W+1+srw_pkg::TIME_W+srw_pkg::SERVER_W
				+srw_pkg::TAG_W +: srw_pkg::FILL_W];
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("[%0t] result beat with nothing outstanding: %h", $realtime, data);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.status !== want.status || got.hit !== want.hit || got.ts !== want.ts ||
					got.server !== want.server || got.tag !== want.tag ||
					got.fill !== want.fill) begin
				errors++;
				if (errors <= 10) begin
					$display("[%0t] mismatch on result %0d", $realtime, checked);
					$display("  expected st=%0d hit=%0d ts=%h srv=%0d tag=%h fill=%0d",
						want.status, want.hit, want.ts, want.server, want.tag, want.fill);
					$display("  actual   st=%0d hit=%0d ts=%h srv=%0d tag=%h fill=%0d",
						got.status, got.hit, got.ts, got.server, got.tag, got.fill);
				end
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [srw_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic [srw_pkg::KIND_W-1:0]     s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [srw_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	window_scoreboard sb;
	logic             steady = 1'b0;
	int unsigned      idle_cycles = 0;
	int unsigned      beats_sent = 0;

	sorted_recent_window DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random back-pressure on the result side
	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 31);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// present one beat, idling at random first, and hold it until taken
	task automatic send_item(input logic [srw_pkg::KIND_W-1:0] kind,
			input logic [srw_pkg::TIME_W-1:0] ts,
			input logic [srw_pkg::SERVER_W-1:0] server,
			input logic [srw_pkg::TAG_W-1:0] tag,
			input logic [srw_pkg::LINE_W-1:0] line);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 31) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= {$urandom, $urandom};
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= srw_pkg::IN_DATA_W'({line, tag, server, ts});
		do
			@(posedge clk);
		while (!s_axis_tready);
		beats_sent++;
	endtask

	// random fields for items whose payload the block ignores
	task automatic send_noise(input logic [srw_pkg::KIND_W-1:0] kind,
			input logic [srw_pkg::LINE_W-1:0] line);
		send_item(kind, srw_pkg::TIME_W'($urandom), srw_pkg::SERVER_W'($urandom),
			srw_pkg::TAG_W'($urandom), line);
	endtask

	initial begin
		logic [srw_pkg::TIME_W-1:0]   now_ts;
		logic [srw_pkg::TIME_W-1:0]   ts;
		logic [srw_pkg::SERVER_W-1:0] server;
		logic [srw_pkg::KEY_W-1:0]    recent_keys[$];
		logic [srw_pkg::KEY_W-1:0]    k;
		logic [srw_pkg::LINE_W-1:0]   line;
		int unsigned                  pick;
		int unsigned                  top_line;

		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = srw_pkg::KIND_INSERT;
		m_axis_tready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty window, rejection, replacement, ordering, reads, clear
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd1);
		send_item(srw_pkg::KIND_INSERT, 31'd100, 4'd5,  16'haaaa, 6'd0);
		send_item(srw_pkg::KIND_INSERT, 31'd50,  4'd5,  16'h1111, 6'd0);
		send_item(srw_pkg::KIND_INSERT, 31'd100, 4'd5,  16'h5555, 6'd0);
		send_item(srw_pkg::KIND_INSERT, 31'd100, 4'd3,  16'h2222, 6'd0);
		send_item(srw_pkg::KIND_INSERT, 31'd100, 4'd15, 16'h3333, 6'd0);
		send_item(srw_pkg::KIND_INSERT, 31'd200, 4'd0,  16'h4444, 6'd0);
		send_item(srw_pkg::KIND_INSERT, 31'd150, 4'd9,  16'h6666, 6'd0);
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd0);
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd2);
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd4);
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd5);
		send_item(srw_pkg::KIND_READ,   31'h7fffffff, 4'd15, 16'hffff, 6'd63);
		send_item(KIND_UNUSED,          31'h7fffffff, 4'd15, 16'hffff, 6'd63);
		send_item(srw_pkg::KIND_INSERT, 31'h7fffffff, 4'd15, 16'hffff, 6'd0);
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd5);
		send_item(srw_pkg::KIND_CLEAR,  31'd0,   4'd0,  16'h0000, 6'd0);
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd1);
		send_item(srw_pkg::KIND_INSERT, 31'd0,   4'd0,  16'h0000, 6'd0);
		send_item(srw_pkg::KIND_INSERT, 31'd0,   4'd0,  16'hbeef, 6'd0);
		send_item(srw_pkg::KIND_READ,   31'd0,   4'd0,  16'h0000, 6'd1);

		// random: mostly near-ordered inserts so the window fills and evicts
		now_ts = 31'd1000;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 500 && n < 800);
			pick = $urandom_range(0, 99);
			if (pick < 58) begin
				pick = $urandom_range(0, 99);
				if (pick < 12 && recent_keys.size() > 0) begin
					k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
					ts = k[srw_pkg::KEY_W-1:srw_pkg::SERVER_W];
					server = k[srw_pkg::SERVER_W-1:0];
				end else if (pick < 20) begin
					ts = srw_pkg::TIME_W'($urandom);
					server = srw_pkg::SERVER_W'($urandom_range(0, 15));
				end else if (pick < 26) begin
					ts = now_ts - srw_pkg::TIME_W'($urandom_range(50, 500));
					server = srw_pkg::SERVER_W'($urandom_range(0, 9));
				end else begin
					now_ts = now_ts + srw_pkg::TIME_W'($urandom_range(0, 2));
					ts = now_ts + srw_pkg::TIME_W'($urandom_range(0, 4));
					server = ($urandom_range(0, 9) == 0)
						? srw_pkg::SERVER_W'($urandom_range(10, 15))
						: srw_pkg::SERVER_W'($urandom_range(0, 9));
				end
				recent_keys.push_back({ts, server});
				if (recent_keys.size() > 8)
					void'(recent_keys.pop_front());
				send_item(srw_pkg::KIND_INSERT, ts, server, srw_pkg::TAG_W'($urandom),
					srw_pkg::LINE_W'($urandom));
			end else if (pick < 96) begin
				top_line = (sb.held == 0) ? 1 : sb.held;
				line = ($urandom_range(0, 9) < 8)
					? srw_pkg::LINE_W'($urandom_range(1, top_line))
					: srw_pkg::LINE_W'($urandom_range(0, 63));
				send_noise(srw_pkg::KIND_READ, line);
			end else if (pick < 97) begin
				send_noise(srw_pkg::KIND_CLEAR, srw_pkg::LINE_W'($urandom));
				pick = $urandom_range(0, 9);
				// move the time base about so high timestamp bits toggle
				if (pick < 3)
					now_ts = srw_pkg::TIME_W'($urandom);
				else if (pick < 5)
					now_ts = 31'h7fffffff - srw_pkg::TIME_W'($urandom_range(0, 300));
			end else begin
				send_noise(KIND_UNUSED, srw_pkg::LINE_W'($urandom));
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d items sent, %0d results checked, %0d mismatches",
			beats_sent, sb.checked, sb.errors);
		$display("Inserts new %0d, replaced %0d, evicted %0d, rejected %0d",
			sb.status_seen[srw_pkg::ST_NEW], sb.status_seen[srw_pkg::ST_REPLACED],
			sb.status_seen[srw_pkg::ST_EVICTED], sb.status_seen[srw_pkg::ST_REJECTED]);
		$display("Reads hit %0d, miss %0d", sb.reads_hit, sb.reads_miss);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
